@@ sv/bref_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Buffer reference dedup package
// Word layouts, request and status codes and controller states.
// ----------------------------------------------------------------------------
package bref_pkg;

    localparam logic REQ_CLEAR = 1'b0;
    localparam logic REQ_ADD   = 1'b1;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_REF_FULL = 2'd1;
    localparam logic [1:0] STATUS_MAP_FULL = 2'd2;

    localparam logic [6:0] SIZE_RESET = 7'd4;

    typedef struct packed {
        logic        req_type;
        logic [31:0] bo_id;
        logic        rd_access;
        logic        wr_access;
        logic [3:0]  priority_req;
    } req_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        is_new;
        logic [7:0]  ref_index;
        logic [13:0] dword_offset;
        logic        out_reading;
        logic        out_writing;
        logic [3:0]  out_priority;
    } rsp_word_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_PROBE_ADDR,
        ST_PROBE_SLOT,
        ST_PROBE_KEY,
        ST_SHIFT_ADDR,
        ST_SHIFT_WR,
        ST_FINISH
    } state_t;

endpackage
`default_nettype wire

@@ sv/bref_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module bref_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ sv/buffer_reference_dedup_hash_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Buffer reference dedup hash core
// Linear-probing hash map with move-to-front that assigns reference indexes.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake           Word
// req       in         req_valid/req_stall req_word_t
// rsp       out        rsp_valid/rsp_stall rsp_word_t
// cfg       in         cfg_valid/cfg_ready reference_size_dwords
//
// An add reads each used slot probed and then its key, stops at a matching key
// or at the free slot that ends a probe, then rewrites every slot from the home
// slot to where the probe stopped, all paced by the single read port of the slot
// memory. The home slot takes extra hash steps when HASH_SLOTS is not a power
// of two. A clear, and reset, sweep the whole slot memory.
// A finished word waits in the output register while the next request is taken.
// ----------------------------------------------------------------------------
module buffer_reference_dedup_hash_core
    import bref_pkg::*;
#(
    parameter int HASH_SLOTS = 512,
    parameter int MAX_REFS   = 256
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_stall,
    input  wire req_word_t req_word,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    output rsp_word_t      rsp_word,
    input  wire logic      cfg_valid,
    output logic           cfg_ready,
    input  wire logic [6:0] cfg_data
);

    localparam int SW = $clog2(HASH_SLOTS);
    localparam int RW = $clog2(MAX_REFS);
    localparam int CW = $clog2(MAX_REFS + 1);
    localparam bit IS_POW2 = (HASH_SLOTS & (HASH_SLOTS - 1)) == 0;
    localparam logic [SW-1:0] LAST_SLOT = SW'(HASH_SLOTS - 1);
    localparam logic [SW-1:0] FOLD      = SW'((1 << 16) % HASH_SLOTS);
    localparam logic [31:0]   RECIP     = 32'((64'd1 << 32) / HASH_SLOTS);
    localparam logic [29:0]   SLOTS_W   = 30'(HASH_SLOTS);
    localparam logic [SW:0]   SLOTS_R   = (SW + 1)'(HASH_SLOTS);

    state_t          state_reg, state_next;
    logic [SW-1:0]   pos_reg, pos_next;
    logic [SW-1:0]   home_reg, home_next;
    logic [SW:0]     steps_reg, steps_next;
    logic [SW:0]     j_reg, j_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [RW-1:0]   idx_reg, idx_next;
    logic [RW-1:0]   cand_reg, cand_next;
    logic [RW-1:0]   carry_reg, carry_next;
    logic            found_reg, found_next;
    logic            report_reg, report_next;
    logic [1:0]      status_reg, status_next;
    logic [32:0]     hash_x_reg, hash_x_next;
    logic [29:0]     hash_y_reg, hash_y_next;
    logic [29:0]     hash_q_reg, hash_q_next;
    logic [1:0]      hash_step_reg, hash_step_next;
    logic [6:0]      size_reg;
    req_word_t       item_reg, item_next;
    rsp_word_t       rsp_reg, rsp_next;
    logic            rsp_valid_reg, rsp_valid_next;

    logic            slot_we;
    logic [RW:0]     slot_wdata;
    logic [RW:0]     slot_rdata;
    logic            key_we;
    logic [31:0]     key_rdata;
    logic [29:0]     fold_sum;
    logic [61:0]     recip_prod;
    logic [29:0]     q_times_n;
    logic [29:0]     rem_full;
    logic [SW:0]     rem_sub;
    logic [SW-1:0]   pos_inc;
    logic [7:0]      idx8;
    logic [14:0]     offset_prod;

    bref_ram #(.WIDTH(RW + 1), .DEPTH(HASH_SLOTS)) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (pos_reg),
        .wdata (slot_wdata),
        .raddr (pos_reg),
        .rdata (slot_rdata)
    );

    bref_ram #(.WIDTH(32), .DEPTH(MAX_REFS)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (RW'(count_reg)),
        .wdata (item_reg.bo_id),
        .raddr (slot_rdata[RW-1:0]),
        .rdata (key_rdata)
    );

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_reg;
    assign cfg_ready = 1'b1;

    assign pos_inc     = (pos_reg == LAST_SLOT) ? '0 : pos_reg + 1'b1;
    assign fold_sum    = 30'(hash_x_reg[32:16]) * 30'(FOLD) + 30'(hash_x_reg[15:0]);
    assign recip_prod  = 62'(hash_y_reg) * 62'(RECIP);
    assign q_times_n   = hash_q_reg * SLOTS_W;
    assign rem_full    = hash_y_reg - q_times_n;
    assign rem_sub     = hash_y_reg[SW:0] - SLOTS_R;
    assign idx8        = 8'(idx_reg);
    assign offset_prod = 15'(idx8) * 15'(size_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            pos_reg       <= '0;
            count_reg     <= '0;
            report_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
            size_reg      <= SIZE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            count_reg     <= count_next;
            report_reg    <= report_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                size_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        home_reg      <= home_next;
        steps_reg     <= steps_next;
        j_reg         <= j_next;
        idx_reg       <= idx_next;
        cand_reg      <= cand_next;
        carry_reg     <= carry_next;
        found_reg     <= found_next;
        status_reg    <= status_next;
        hash_x_reg    <= hash_x_next;
        hash_y_reg    <= hash_y_next;
        hash_q_reg    <= hash_q_next;
        hash_step_reg <= hash_step_next;
        item_reg      <= item_next;
        rsp_reg       <= rsp_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        home_next      = home_reg;
        steps_next     = steps_reg;
        j_next         = j_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        cand_next      = cand_reg;
        carry_next     = carry_reg;
        found_next     = found_reg;
        report_next    = report_reg;
        status_next    = status_reg;
        hash_x_next    = hash_x_reg;
        hash_y_next    = hash_y_reg;
        hash_q_next    = hash_q_reg;
        hash_step_next = hash_step_reg;
        item_next      = item_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        slot_we        = 1'b0;
        slot_wdata     = '0;
        key_we         = 1'b0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                slot_we = 1'b1;
                if (pos_reg == LAST_SLOT)
                begin
                    count_next = '0;
                    state_next = report_reg ? ST_FINISH : ST_IDLE;
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    item_next   = req_word;
                    found_next  = 1'b0;
                    status_next = STATUS_OK;
                    steps_next  = '0;
                    if (req_word.req_type == REQ_CLEAR)
                    begin
                        report_next = 1'b1;
                        pos_next    = '0;
                        state_next  = ST_CLEAR;
                    end
                    else if (IS_POW2)
                    begin
                        home_next  = SW'({req_word.bo_id, 1'b0});
                        pos_next   = SW'({req_word.bo_id, 1'b0});
                        state_next = ST_PROBE_ADDR;
                    end
                    else
                    begin
                        hash_x_next    = {req_word.bo_id, 1'b0};
                        hash_step_next = '0;
                        state_next     = ST_HASH;
                    end
                end
            end
            ST_HASH:
            begin
                hash_step_next = hash_step_reg + 1'b1;
                unique case (hash_step_reg)
                    2'd0:
                    begin
                        hash_y_next = fold_sum;
                    end
                    2'd1:
                    begin
                        hash_q_next = recip_prod[61:32];
                    end
                    2'd2:
                    begin
                        hash_y_next = rem_full;
                    end
                    2'd3:
                    begin
                        if (hash_y_reg[SW:0] >= SLOTS_R)
                        begin
                            home_next = SW'(rem_sub);
                        end
                        else
                        begin
                            home_next = SW'(hash_y_reg[SW:0]);
                        end
                        pos_next   = home_next;
                        state_next = ST_PROBE_ADDR;
                    end
                endcase
            end
            ST_PROBE_ADDR:
            begin
                state_next = ST_PROBE_SLOT;
            end
            ST_PROBE_SLOT:
            begin
                cand_next = slot_rdata[RW-1:0];
                if (slot_rdata[RW])
                begin
                    state_next = ST_PROBE_KEY;
                end
                else if (count_reg >= CW'(MAX_REFS))
                begin
                    status_next = STATUS_REF_FULL;
                    state_next  = ST_FINISH;
                end
                else
                begin
                    key_we     = 1'b1;
                    idx_next   = RW'(count_reg);
                    carry_next = RW'(count_reg);
                    count_next = count_reg + 1'b1;
                    pos_next   = home_reg;
                    j_next     = '0;
                    state_next = ST_SHIFT_ADDR;
                end
            end
            ST_PROBE_KEY:
            begin
                if (key_rdata == item_reg.bo_id)
                begin
                    found_next = 1'b1;
                    idx_next   = cand_reg;
                    carry_next = cand_reg;
                    pos_next   = home_reg;
                    j_next     = '0;
                    state_next = ST_SHIFT_ADDR;
                end
                else if (steps_reg == (SW + 1)'(HASH_SLOTS - 1))
                begin
                    status_next = STATUS_MAP_FULL;
                    state_next  = ST_FINISH;
                end
                else
                begin
                    steps_next = steps_reg + 1'b1;
                    pos_next   = pos_inc;
                    state_next = ST_PROBE_ADDR;
                end
            end
            ST_SHIFT_ADDR:
            begin
                state_next = ST_SHIFT_WR;
            end
            ST_SHIFT_WR:
            begin
                slot_we    = 1'b1;
                slot_wdata = {1'b1, carry_reg};
                carry_next = slot_rdata[RW-1:0];
                if (j_reg == steps_reg)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    pos_next   = pos_inc;
                    state_next = ST_SHIFT_ADDR;
                end
            end
            ST_FINISH:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next = '0;
                    if (item_reg.req_type == REQ_ADD)
                    begin
                        rsp_next.status       = status_reg;
                        rsp_next.out_reading  = item_reg.rd_access;
                        rsp_next.out_writing  = item_reg.wr_access;
                        rsp_next.out_priority = item_reg.priority_req;
                        if (status_reg == STATUS_OK)
                        begin
                            rsp_next.is_new       = !found_reg;
                            rsp_next.ref_index    = idx8;
                            rsp_next.dword_offset = offset_prod[13:0];
                        end
                    end
                    rsp_valid_next = 1'b1;
                    report_next    = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire
